### rtl/pidtm_pkg.sv
// Package for the two-mode PID controller.
// Holds field widths, register and command codes, and the configuration struct.
// No dependencies.
package pidtm_pkg;

    localparam int DATA_WIDTH_DEF     = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int GAIN_W    = 16;  // Q8.8 gains
    localparam int LIM_W     = 15;  // setpoint, change and output limits
    localparam int SUM_LIM_W = 23;  // error sum limit
    localparam int SUM_W     = 24;  // error sum, signed
    localparam int DRV_W     = 16;  // drive and peak state, signed

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // 0.99 as Q0.16
    localparam int              DECAY_W   = 16;
    localparam logic [DECAY_W-1:0] DECAY_Q16 = 16'd64881;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP             = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_TS          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_TS          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_LIMIT      = 3'd7;

    localparam logic MODE_INCR = 1'b0;
    localparam logic MODE_POS  = 1'b1;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [GAIN_W-1:0]    kp;
        logic [GAIN_W-1:0]    ki_ts;
        logic [GAIN_W-1:0]    kd_ts;
        logic [LIM_W-1:0]     sp_lim;
        logic [LIM_W-1:0]     chg_lim;
        logic [LIM_W-1:0]     out_lim;
        logic [SUM_LIM_W-1:0] sum_lim;
    } t_cfg;

endpackage

### rtl/pidtm_cfg_regs.sv
// Configuration register file of the two-mode PID controller.
// Depends on pidtm_pkg.
module pidtm_cfg_regs
    import pidtm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= MODE_POS;
            r_cfg.kp      <= '0;
            r_cfg.ki_ts   <= '0;
            r_cfg.kd_ts   <= '0;
            r_cfg.sp_lim  <= '1;
            r_cfg.chg_lim <= '1;
            r_cfg.out_lim <= '1;
            r_cfg.sum_lim <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:           r_cfg.mode    <= i_cfg_data[0];
                CFG_KP:             r_cfg.kp      <= i_cfg_data[GAIN_W-1:0];
                CFG_KI_TS:          r_cfg.ki_ts   <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_TS:          r_cfg.kd_ts   <= i_cfg_data[GAIN_W-1:0];
                CFG_SETPOINT_LIMIT: r_cfg.sp_lim  <= i_cfg_data[LIM_W-1:0];
                CFG_CHANGE_LIMIT:   r_cfg.chg_lim <= i_cfg_data[LIM_W-1:0];
                CFG_OUTPUT_LIMIT:   r_cfg.out_lim <= i_cfg_data[LIM_W-1:0];
                CFG_SUM_LIMIT:      r_cfg.sum_lim <= i_cfg_data[SUM_LIM_W-1:0];
            endcase
        end
    end

endmodule

### rtl/pidtm_step.sv
// One control update of the two-mode PID controller, combinational.
// Takes the registered word, configuration and state; gives next state and result.
// Depends on pidtm_pkg.
module pidtm_step
    import pidtm_pkg::*;
#(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    localparam int ERR_W = (DATA_WIDTH + 1 > DRV_W + 1) ? DATA_WIDTH + 1 : DRV_W + 1
)
(
    input  t_cfg                          i_cfg,
    input  logic                          i_cmd,
    input  logic signed [DATA_WIDTH-1:0]  i_meas,
    input  logic signed [DATA_WIDTH-1:0]  i_sp,
    input  logic                          i_rst_int,
    input  logic signed [DRV_W-1:0]       i_drive,
    input  logic signed [DRV_W-1:0]       i_peak_hi,
    input  logic signed [DRV_W-1:0]       i_peak_lo,
    input  logic signed [ERR_W-1:0]       i_last_err,
    input  logic signed [ERR_W-1:0]       i_prev_err,
    input  logic signed [SUM_W-1:0]       i_err_sum,
    output logic signed [DRV_W-1:0]       o_drive,
    output logic signed [DRV_W-1:0]       o_peak_hi,
    output logic signed [DRV_W-1:0]       o_peak_lo,
    output logic signed [ERR_W-1:0]       o_last_err,
    output logic signed [ERR_W-1:0]       o_prev_err,
    output logic signed [SUM_W-1:0]       o_err_sum,
    output logic                          o_sat
);

    localparam int ACC_W   = (ERR_W + 20 > GAIN_W + SUM_W + 1) ? ERR_W + 20
                                                             : GAIN_W + SUM_W + 1;
    localparam int SE_W    = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
    localparam int HALF_SH = (GAIN_FRAC_BITS == 0) ? 0 : GAIN_FRAC_BITS - 1;
    localparam logic signed [ACC_W-1:0] HALF =
        (GAIN_FRAC_BITS == 0) ? '0 : (ACC_W'(1) << HALF_SH);

    logic signed [ERR_W-1:0]          sp_lim, sp_w, sp_c, meas_w, err;
    logic signed [ERR_W:0]            d1;
    logic signed [ERR_W+1:0]          d2;
    logic signed [GAIN_W+ERR_W:0]     p_p;
    logic signed [GAIN_W+ERR_W-1:0]   p_i, p_pe;
    logic signed [GAIN_W+ERR_W+1:0]   p_d;
    logic signed [SUM_W-1:0]          es0, es_dec;
    logic signed [GAIN_W+SUM_W-1:0]   p_s;
    logic signed [ACC_W-1:0]          acc, rnd, ol_a, cl_a;
    logic signed [DRV_W:0]            inc;
    logic signed [DRV_W+1:0]          dsum, ol_d;
    logic signed [DRV_W-1:0]          drv_inc, drv_pos, drv_nx;
    logic                             hi, lo, allow;
    logic        [SUM_W-1:0]          mag, dmag;
    logic        [SUM_W+DECAY_W-1:0]  dprod;
    logic signed [SE_W-1:0]           es_add, es_pre, sl;

    always_comb begin
        // setpoint clamp and error
        sp_lim = $signed(ERR_W'(i_cfg.sp_lim));
        sp_w   = ERR_W'(i_sp);
        meas_w = ERR_W'(i_meas);
        if (sp_w > sp_lim)       sp_c = sp_lim;
        else if (sp_w < -sp_lim) sp_c = -sp_lim;
        else                     sp_c = sp_w;
        err = sp_c - meas_w;

        // incremental products
        d1  = (ERR_W+1)'(err) - (ERR_W+1)'(i_last_err);
        d2  = (ERR_W+2)'(err) - ((ERR_W+2)'(i_last_err) <<< 1) + (ERR_W+2)'(i_prev_err);
        p_p = $signed(i_cfg.kp) * d1;
        p_i = $signed(i_cfg.ki_ts) * err;
        p_d = $signed(i_cfg.kd_ts) * d2;

        // positional products; zero gain or request clears the sum first
        es0  = (i_cfg.ki_ts == '0 || i_rst_int) ? '0 : i_err_sum;
        p_pe = $signed(i_cfg.kp) * err;
        p_s  = $signed(i_cfg.ki_ts) * es0;

        if (i_cfg.mode == MODE_POS) acc = ACC_W'(p_pe) + ACC_W'(p_s);
        else                        acc = ACC_W'(p_p) + ACC_W'(p_i) + ACC_W'(p_d);

        // round half up, then floor
        rnd  = (acc + HALF) >>> GAIN_FRAC_BITS;
        ol_a = $signed(ACC_W'(i_cfg.out_lim));
        cl_a = $signed(ACC_W'(i_cfg.chg_lim));

        // incremental: clamp step, accumulate, clamp drive
        if (rnd > cl_a)       inc = $signed((DRV_W+1)'(i_cfg.chg_lim));
        else if (rnd < -cl_a) inc = -$signed((DRV_W+1)'(i_cfg.chg_lim));
        else                  inc = rnd[DRV_W:0];
        dsum = (DRV_W+2)'(i_drive) + (DRV_W+2)'(inc);
        ol_d = $signed((DRV_W+2)'(i_cfg.out_lim));
        if (dsum > ol_d)       drv_inc = ol_d[DRV_W-1:0];
        else if (dsum < -ol_d) drv_inc = -ol_d[DRV_W-1:0];
        else                   drv_inc = dsum[DRV_W-1:0];

        // positional: clamp raw output
        hi = rnd > ol_a;
        lo = rnd < -ol_a;
        if (hi)      drv_pos = ol_a[DRV_W-1:0];
        else if (lo) drv_pos = -ol_a[DRV_W-1:0];
        else         drv_pos = rnd[DRV_W-1:0];

        // decay by 0.99 on magnitude, truncating toward zero
        mag    = es0[SUM_W-1] ? $unsigned(-es0) : $unsigned(es0);
        dprod  = mag * DECAY_Q16;
        dmag   = dprod[SUM_W+DECAY_W-1:DECAY_W];
        es_dec = es0[SUM_W-1] ? -$signed(dmag) : $signed(dmag);

        // conditional integration
        allow  = (!hi && !lo) || (hi && err[ERR_W-1])
                 || (lo && !err[ERR_W-1] && err != '0);
        es_add = SE_W'(es0) + SE_W'(err);
        if (err == '0 || sp_c == '0) es_pre = SE_W'(es_dec);
        else if (allow)              es_pre = es_add;
        else                         es_pre = SE_W'(es0);
        sl = $signed(SE_W'(i_cfg.sum_lim));

        // next state
        o_sat      = 1'b0;
        o_last_err = i_last_err;
        o_prev_err = i_prev_err;
        o_err_sum  = i_err_sum;
        if (i_cfg.mode == MODE_POS) begin
            drv_nx = drv_pos;
            o_sat  = hi || lo;
            if (es_pre > sl)       o_err_sum = sl[SUM_W-1:0];
            else if (es_pre < -sl) o_err_sum = -sl[SUM_W-1:0];
            else                   o_err_sum = es_pre[SUM_W-1:0];
        end else begin
            drv_nx     = drv_inc;
            o_last_err = err;
            o_prev_err = i_last_err;
        end

        o_drive   = drv_nx;
        o_peak_hi = (drv_nx > i_peak_hi) ? drv_nx : i_peak_hi;
        o_peak_lo = (drv_nx < i_peak_lo) ? drv_nx : i_peak_lo;

        if (i_cmd == CMD_CLEAR) begin
            o_drive    = '0;
            o_peak_hi  = '0;
            o_peak_lo  = '0;
            o_last_err = '0;
            o_prev_err = '0;
            o_err_sum  = '0;
            o_sat      = 1'b0;
        end
    end

endmodule

### rtl/pid_controller_two_mode_unit.sv
// Top level of the two-mode PID controller (incremental PID / positional PI).
// Depends on pidtm_pkg, pidtm_cfg_regs and pidtm_step.
//
//  channel   | dir | handshake                       | payload
//  ----------+-----+---------------------------------+----------------------------------
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tdata: measurement, setpoint,
//            |     |                                 |   reset_integral; tuser: cmd
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata: drive, peak_high, peak_low,
//            |     |                                 |   saturated
//  cfg       | in  | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One word per cycle while results are taken; words pass input, then result register.
// The input register feeds the control update, which writes the controller state and
// the result register in the same edge, so the next word sees the updated state.
// A full result register that is not taken stalls the update; the input register
// still takes one more word. Reset clears state and loads register defaults
// (positional mode, zero gains, full-scale limits). The cfg port never stalls.
module pid_controller_two_mode_unit
    import pidtm_pkg::*;
#(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 1 + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((3 * DATA_WIDTH + 1 + 7) / 8) * 8
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input words
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // low up: measurement, setpoint, reset_integral, zero fill
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // cmd
    input  logic                   i_s_axis_tuser,
    // result words
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // low up: drive, peak_high, peak_low, saturated, zero fill
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ERR_W = (DATA_WIDTH + 1 > DRV_W + 1) ? DATA_WIDTH + 1 : DRV_W + 1;

    t_cfg cfg;

    // input register
    logic                          r_in_vld;
    logic                          r_in_cmd;
    logic signed [DATA_WIDTH-1:0]  r_in_meas;
    logic signed [DATA_WIDTH-1:0]  r_in_sp;
    logic                          r_in_rst_int;

    // controller state
    logic signed [DRV_W-1:0]       r_drive, r_peak_hi, r_peak_lo;
    logic signed [ERR_W-1:0]       r_last_err, r_prev_err;
    logic signed [SUM_W-1:0]       r_err_sum;

    logic signed [DRV_W-1:0]       n_drive, n_peak_hi, n_peak_lo;
    logic signed [ERR_W-1:0]       n_last_err, n_prev_err;
    logic signed [SUM_W-1:0]       n_err_sum;
    logic                          n_sat;

    // result register
    logic                          r_out_vld;
    logic signed [DRV_W-1:0]       r_out_drive, r_out_hi, r_out_lo;
    logic                          r_out_sat;

    logic advance;
    logic s_take;

    pidtm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pidtm_step #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_step (
        .i_cfg      (cfg),
        .i_cmd      (r_in_cmd),
        .i_meas     (r_in_meas),
        .i_sp       (r_in_sp),
        .i_rst_int  (r_in_rst_int),
        .i_drive    (r_drive),
        .i_peak_hi  (r_peak_hi),
        .i_peak_lo  (r_peak_lo),
        .i_last_err (r_last_err),
        .i_prev_err (r_prev_err),
        .i_err_sum  (r_err_sum),
        .o_drive    (n_drive),
        .o_peak_hi  (n_peak_hi),
        .o_peak_lo  (n_peak_lo),
        .o_last_err (n_last_err),
        .o_prev_err (n_prev_err),
        .o_err_sum  (n_err_sum),
        .o_sat      (n_sat)
    );

    // update fires when the input word can move into a free result slot
    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_cmd     <= i_s_axis_tuser;
            r_in_meas    <= i_s_axis_tdata[DATA_WIDTH-1:0];
            r_in_sp      <= i_s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            r_in_rst_int <= i_s_axis_tdata[2*DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive    <= '0;
            r_peak_hi  <= '0;
            r_peak_lo  <= '0;
            r_last_err <= '0;
            r_prev_err <= '0;
            r_err_sum  <= '0;
        end else if (advance) begin
            r_drive    <= n_drive;
            r_peak_hi  <= n_peak_hi;
            r_peak_lo  <= n_peak_lo;
            r_last_err <= n_last_err;
            r_prev_err <= n_prev_err;
            r_err_sum  <= n_err_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_drive <= n_drive;
            r_out_hi    <= n_peak_hi;
            r_out_lo    <= n_peak_lo;
            r_out_sat   <= n_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[DATA_WIDTH-1:0]              = DATA_WIDTH'(r_out_drive);
        o_m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]   = DATA_WIDTH'(r_out_hi);
        o_m_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH] = DATA_WIDTH'(r_out_lo);
        o_m_axis_tdata[3*DATA_WIDTH]                = r_out_sat;
    end

    // a clear word yields an all-zero result
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_cmd == CMD_CLEAR |=>
            r_out_drive == '0 && r_out_hi == '0 && r_out_lo == '0 && !r_out_sat)
        else $error("clear word did not give a zero result");

    // peaks bracket zero and the drive
    a_peaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_hi >= 0 && r_out_lo <= 0
                      && r_out_drive <= r_out_hi && r_out_drive >= r_out_lo)
        else $error("peak values do not bracket drive");

    // saturation flag is only raised by the positional controller
    a_sat_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && cfg.mode == MODE_INCR |=> !r_out_sat)
        else $error("saturated raised in incremental mode");

    // a waiting input word is held until it updates the controller
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in_meas) && $stable(r_in_sp)
                                 && $stable(r_in_cmd))
        else $error("input word lost before update");

    // state does not move without an update
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_drive) && $stable(r_err_sum) && $stable(r_last_err))
        else $error("controller state changed without an update");

endmodule

### test/testbench.sv
// Self-checking bench for pid_controller_two_mode_unit.
// Streams control words through the block, predicts every result word in-line and
// compares field by field. Depends on pidtm_pkg and the RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pidtm_pkg::*;

    localparam int DW    = DATA_WIDTH_DEF;
    localparam int IN_W  = ((2 * DW + 1 + 7) / 8) * 8;
    localparam int OUT_W = ((3 * DW + 1 + 7) / 8) * 8;
    localparam int FRAC  = GAIN_FRAC_BITS_DEF;

    // one input word as the sender sees it
    typedef struct packed {
        logic          cmd;
        logic          rst_int;
        logic [DW-1:0] sp;
        logic [DW-1:0] meas;
    } t_ctl_word;

    // one result word
    typedef struct packed {
        logic [DW-1:0] drive;
        logic [DW-1:0] peak_high;
        logic [DW-1:0] peak_low;
        logic          saturated;
    } t_drive_word;

    // ---------------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ---------------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_valid   = 1'b0;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_W-1:0]      o_m_axis_tdata;
    logic                  o_cfg_ready;

    always #4 clk = ~clk;

    pid_controller_two_mode_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // ---------------------------------------------------------------------------------
    // Controller shadow: register copy (reset values) and state copy
    // ---------------------------------------------------------------------------------
    logic   c_mode    = MODE_POS;
    longint c_kp      = 0;
    longint c_ki      = 0;
    longint c_kd      = 0;
    longint c_sp_lim  = 32767;
    longint c_chg_lim = 32767;
    longint c_out_lim = 32767;
    longint c_sum_lim = 8388607;

    longint st_drive    = 0;
    longint st_last_err = 0;
    longint st_prev_err = 0;
    longint st_err_sum  = 0;
    longint st_max      = 0;
    longint st_min      = 0;

    t_ctl_word   ctl_pending[$];   // words waiting for the driver
    t_drive_word drive_due[$];     // predicted result words, oldest first
    int          n_fail = 0;

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Q8.8 product back to integer: round half up (add half, floor)
    function automatic longint round_q(input longint v);
        return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    // |x| * 0.99, truncated toward zero, sign kept
    function automatic longint decay99(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag * longint'(DECAY_Q16)) >> 16;
        return (v < 0) ? -mag : mag;
    endfunction

    // Advances the shadow by one accepted word and returns the result it must produce.
    function automatic t_drive_word pid_update(input t_ctl_word w);
        longint      meas, sp, err, acc, step, raw;
        logic        hi, lo;
        t_drive_word r;
        hi = 1'b0;
        lo = 1'b0;
        if (w.cmd == CMD_CLEAR) begin
            st_drive    = 0;
            st_last_err = 0;
            st_prev_err = 0;
            st_err_sum  = 0;
            st_max      = 0;
            st_min      = 0;
        end else begin
            meas = $signed(w.meas);
            sp   = clamp_sym($signed(w.sp), c_sp_lim);
            err  = sp - meas;
            if (c_mode == MODE_INCR) begin
                // reset_integral has no meaning here
                acc = c_kp * (err - st_last_err) + c_ki * err
                    + c_kd * (err - 2 * st_last_err + st_prev_err);
                step        = clamp_sym(round_q(acc), c_chg_lim);
                st_drive    = clamp_sym(st_drive + step, c_out_lim);
                st_prev_err = st_last_err;
                st_last_err = err;
            end else begin
                if (c_ki == 0 || w.rst_int) st_err_sum = 0;
                raw      = round_q(c_kp * err + c_ki * st_err_sum);
                hi       = raw > c_out_lim;
                lo       = raw < -c_out_lim;
                st_drive = clamp_sym(raw, c_out_lim);
                // zero error or zero target: bleed the integral instead of adding
                if (err == 0 || sp == 0)
                    st_err_sum = decay99(st_err_sum);
                else if ((!hi && !lo) || (hi && err < 0) || (lo && err > 0))
                    st_err_sum += err;
                st_err_sum = clamp_sym(st_err_sum, c_sum_lim);
            end
            if (st_drive > st_max) st_max = st_drive;
            if (st_drive < st_min) st_min = st_drive;
        end
        r.drive     = st_drive[DW-1:0];
        r.peak_high = st_max[DW-1:0];
        r.peak_low  = st_min[DW-1:0];
        r.saturated = hi | lo;
        return r;
    endfunction

    // ---------------------------------------------------------------------------------
    // Driver: bursts of words from ctl_pending with random gaps in between
    // ---------------------------------------------------------------------------------
    t_ctl_word cur_word   = '0;
    int        burst_left = 1;
    int        gap_left   = 0;

    always @(posedge clk) begin
        t_ctl_word nxt;
        logic      nxt_valid;
        nxt       = cur_word;
        nxt_valid = s_valid;
        if (rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                drive_due.push_back(pid_update(cur_word));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (ctl_pending.size() > 0) begin
                    nxt       = ctl_pending.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // about a third of the bursts run straight into the next one
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
                        if ($urandom_range(15) == 0) gap_left = $urandom_range(10, 30);
                    end
                end
            end
        end
        cur_word <= nxt;
        s_valid  <= nxt_valid;
        s_tdata  <= {{(IN_W - 2 * DW - 1){1'b0}}, nxt.rst_int, nxt.sp, nxt.meas};
        s_tuser  <= nxt.cmd;
    end

    // ---------------------------------------------------------------------------------
    // Monitor: checks each result word and runs the receiver's stall pattern
    // ---------------------------------------------------------------------------------
    int stall_pct  = 0;
    int pat_left   = 0;
    int hold_left  = 0;
    int since_hold = 0;

    function automatic void cmp_field(input string nm, input longint want,
                                      input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk) begin
        t_drive_word got, want;
        logic        nxt_ready;
        nxt_ready = m_ready;
        if (rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                got.drive     = o_m_axis_tdata[DW-1:0];
                got.peak_high = o_m_axis_tdata[2*DW-1:DW];
                got.peak_low  = o_m_axis_tdata[3*DW-1:2*DW];
                got.saturated = o_m_axis_tdata[3*DW];
                if (drive_due.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, got);
                    n_fail++;
                end else begin
                    want = drive_due.pop_front();
                    cmp_field("drive", $signed(want.drive), $signed(got.drive));
                    cmp_field("peak_high", $signed(want.peak_high), $signed(got.peak_high));
                    cmp_field("peak_low", $signed(want.peak_low), $signed(got.peak_low));
                    cmp_field("saturated", want.saturated, got.saturated);
                end
            end
            since_hold++;
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (ctl_pending.size() > 16 && since_hold > 400) begin
                // long back-pressure while the sender still has plenty queued
                hold_left  = 150;
                since_hold = 0;
                nxt_ready  = 1'b0;
            end else begin
                if (pat_left == 0) begin
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                    pat_left = $urandom_range(16, 80);
                end
                pat_left--;
                nxt_ready = ($urandom_range(99) >= stall_pct);
            end
        end
        m_ready <= nxt_ready;
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------
    function automatic t_ctl_word mk(input logic cmd, input longint meas, input longint sp,
                                     input logic rst_int);
        t_ctl_word w;
        w.cmd     = cmd;
        w.meas    = meas[DW-1:0];
        w.sp      = sp[DW-1:0];
        w.rst_int = rst_int;
        return w;
    endfunction

    function automatic longint extreme16();
        case ($urandom_range(2))
            0:       return -32768;
            1:       return 32767;
            default: return 0;
        endcase
    endfunction

    function automatic t_ctl_word rand_word();
        longint meas, sp;
        case ($urandom_range(9))
            0:          meas = extreme16();
            1, 2, 3, 4: meas = longint'($urandom_range(4000)) - 2000;
            default:    meas = longint'($urandom_range(65535)) - 32768;
        endcase
        case ($urandom_range(9))
            0:       sp = 0;                  // target zero: integral decays
            1:       sp = meas;               // zero error unless clamped
            2:       sp = extreme16();
            3, 4, 5: sp = meas + longint'($urandom_range(600)) - 300;
            default: sp = longint'($urandom_range(65535)) - 32768;
        endcase
        return mk(($urandom_range(99) < 3) ? CMD_CLEAR : CMD_STEP, meas, sp,
                  $urandom_range(99) < 6);
    endfunction

    function automatic longint pick_gain();
        case ($urandom_range(9))
            0, 1:          return extreme16();
            2, 3, 4, 5, 6: return longint'($urandom_range(1200)) - 600;
            default:       return longint'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic longint pick_limit(input int top);
        case ($urandom_range(19))
            0, 1, 2:          return 0;
            3, 4, 5:          return top;
            6, 7, 8, 9, 10:   return $urandom_range(1, 3000);
            default:          return $urandom_range(top);
        endcase
    endfunction

    // One register write; the shadow copy follows at the handshake.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:           c_mode    = val[0];
            CFG_KP:             c_kp      = $signed(val[GAIN_W-1:0]);
            CFG_KI_TS:          c_ki      = $signed(val[GAIN_W-1:0]);
            CFG_KD_TS:          c_kd      = $signed(val[GAIN_W-1:0]);
            CFG_SETPOINT_LIMIT: c_sp_lim  = val[LIM_W-1:0];
            CFG_CHANGE_LIMIT:   c_chg_lim = val[LIM_W-1:0];
            CFG_OUTPUT_LIMIT:   c_out_lim = val[LIM_W-1:0];
            CFG_SUM_LIMIT:      c_sum_lim = val[SUM_LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_cfg(input logic mode, input longint kp, input longint ki,
                            input longint kd, input longint spl, input longint chl,
                            input longint outl, input longint suml);
        set_reg(CFG_MODE, mode);
        set_reg(CFG_KP, kp);
        set_reg(CFG_KI_TS, ki);
        set_reg(CFG_KD_TS, kd);
        set_reg(CFG_SETPOINT_LIMIT, spl);
        set_reg(CFG_CHANGE_LIMIT, chl);
        set_reg(CFG_OUTPUT_LIMIT, outl);
        set_reg(CFG_SUM_LIMIT, suml);
    endtask

    // Sender holds off until every word is through and every result is back.
    task automatic drain();
        while (ctl_pending.size() != 0 || s_valid || drive_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ---------------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------------
    initial begin
        int ph, k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults: positional, zero gains, so the output stays at zero
        ctl_pending.push_back(mk(CMD_STEP, -32768, 32767, 1'b0));
        ctl_pending.push_back(mk(CMD_STEP, 32767, -32768, 1'b1));
        ctl_pending.push_back(mk(CMD_CLEAR, 1234, -77, 1'b0));
        drain();

        // positional PI, moderate gains and limits
        load_cfg(MODE_POS, 256, 64, 0, 1000, 32767, 2000, 5000);
        ctl_pending.push_back(mk(CMD_STEP, 0, 500, 1'b0));
        ctl_pending.push_back(mk(CMD_STEP, 0, 500, 1'b0));
        ctl_pending.push_back(mk(CMD_STEP, -32768, 32767, 1'b0));  // saturates high
        ctl_pending.push_back(mk(CMD_STEP, 32767, -32768, 1'b0));  // saturates low
        ctl_pending.push_back(mk(CMD_STEP, 300, 300, 1'b0));       // zero error
        ctl_pending.push_back(mk(CMD_STEP, 50, 0, 1'b0));          // zero target
        ctl_pending.push_back(mk(CMD_STEP, 0, 100, 1'b1));         // integral reset
        ctl_pending.push_back(mk(CMD_CLEAR, 0, 0, 1'b0));
        ctl_pending.push_back(mk(CMD_STEP, 0, 100, 1'b0));
        drain();

        // incremental PID with extreme gains and a tight step limit
        load_cfg(MODE_INCR, 32767, -32768, 32767, 1000, 100, 250, 8388607);
        ctl_pending.push_back(mk(CMD_STEP, -32768, 32767, 1'b0));
        ctl_pending.push_back(mk(CMD_STEP, 32767, -32768, 1'b0));
        ctl_pending.push_back(mk(CMD_STEP, 5, 10, 1'b1));          // flag has no effect
        ctl_pending.push_back(mk(CMD_STEP, 5, 10, 1'b0));
        ctl_pending.push_back(mk(CMD_CLEAR, -1, 1, 1'b1));
        ctl_pending.push_back(mk(CMD_STEP, 0, 0, 1'b0));
        drain();

        // random phases, first two at the register extremes
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_cfg(MODE_POS, 32767, 32767, 32767, 32767, 32767, 32767, 8388607);
                1: load_cfg(MODE_INCR, -32768, -32768, -32768, 0, 0, 0, 0);
                default:
                    load_cfg($urandom_range(1), pick_gain(), pick_gain(), pick_gain(),
                             pick_limit(32767), pick_limit(32767), pick_limit(32767),
                             pick_limit(8388607));
            endcase
            for (k = 0; k < 75; k++)
                ctl_pending.push_back(rand_word());
            drain();
        end

        repeat (10) @(negedge clk);
        if (drive_due.size() != 0) begin
            $display("%0t: result words missing, expected %0d more, actual 0",
                     $time, drive_due.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/pidtm_pkg.sv
rtl/pidtm_cfg_regs.sv
rtl/pidtm_step.sv
rtl/pid_controller_two_mode_unit.sv
test/testbench.sv
